[src/she_pkg.sv]
// shared types, constants and helpers for the string hash engine
// no dependencies; imported by every module of the block
package she_pkg;

  localparam int unsigned HASH_W      = 31;
  localparam int unsigned BUCKET_W    = 16;
  localparam int unsigned CNT_W       = $clog2(HASH_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // hash selector codes
  typedef enum logic [2:0] {
    ALG_SDBM = 3'd0,
    ALG_RS   = 3'd1,
    ALG_JS   = 3'd2,
    ALG_PJW  = 3'd3,
    ALG_ELF  = 3'd4,
    ALG_BKDR = 3'd5,
    ALG_DJB  = 3'd6,
    ALG_AP   = 3'd7
  } alg_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd2;

  localparam alg_e                  ALG_RESET     = ALG_ELF;
  localparam logic                  SIGNED_RESET  = 1'b1;
  localparam logic [BUCKET_W-1:0]   BUCKET_RESET  = 16'd1800;

  localparam logic [31:0] RS_STEP    = 32'd378551;
  localparam logic [31:0] RS_START   = 32'd63689;
  localparam logic [31:0] JS_START   = 32'd1315423911;
  localparam logic [31:0] DJB_START  = 32'd5381;
  localparam logic [31:0] TOP_NIBBLE = 32'hF000_0000;

  typedef logic [HASH_W-1:0] hash_t;

  // settings the hashing front end works under
  typedef struct packed {
    alg_e algorithm;
    logic signed_bytes;
  } front_cfg_t;

  function automatic logic [31:0] start_value(alg_e alg);
    logic [31:0] val;
    case (alg)
      ALG_JS:  val = JS_START;
      ALG_DJB: val = DJB_START;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

[src/she_front.sv]
// front end: takes string bytes, keeps the running hash state
// depends on she_pkg; pushes finished hashes into she_queue
module she_front import she_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  front_cfg_t cfg_i,
  input  logic       alg_we_i,
  input  alg_e       alg_wdata_i,
  input  logic       in_valid_i,
  input  logic [7:0] byte_in_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output hash_t      q_data_o
);

  logic [31:0] hash_q, hash_d;
  logic [31:0] rs_mult_q;
  logic        odd_q;

  logic        accept;
  logic        term;
  logic [31:0] c;
  logic [31:0] rs_prod;
  logic [31:0] rs_next;
  logic [31:0] nib_t;
  logic [31:0] nib_top;
  logic [31:0] nib_res;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign term       = accept & (byte_in_i == 8'd0);
  assign q_push_o   = term;
  assign q_data_o   = hash_q[HASH_W-1:0];

  assign c = (cfg_i.signed_bytes && byte_in_i[7]) ? {24'hFF_FFFF, byte_in_i}
                                                  : {24'h00_0000, byte_in_i};

  assign rs_prod = hash_q * rs_mult_q;
  assign rs_next = rs_mult_q * RS_STEP;

  // pjw and elf reduce to the same update
  assign nib_t   = (hash_q << 4) + c;
  assign nib_top = nib_t & TOP_NIBBLE;
  assign nib_res = (nib_top != 32'd0) ? ((nib_t ^ (nib_top >> 24)) & ~TOP_NIBBLE) : nib_t;

  always_comb begin
    unique case (cfg_i.algorithm)
      ALG_SDBM: hash_d = c + (hash_q << 16) + (hash_q << 6) - hash_q;
      ALG_RS:   hash_d = rs_prod + c;
      ALG_JS:   hash_d = hash_q ^ ((hash_q << 5) + c + (hash_q >> 2));
      ALG_PJW:  hash_d = nib_res;
      ALG_ELF:  hash_d = nib_res;
      ALG_BKDR: hash_d = (hash_q << 7) + (hash_q << 1) + hash_q + c;
      ALG_DJB:  hash_d = hash_q + (hash_q << 5) + c;
      ALG_AP: begin
        if (!odd_q) begin
          hash_d = hash_q ^ ((hash_q << 7) ^ c ^ (hash_q >> 3));
        end else begin
          hash_d = hash_q ^ ~((hash_q << 11) ^ c ^ (hash_q >> 5));
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= start_value(ALG_RESET);
      rs_mult_q <= RS_START;
      odd_q     <= 1'b0;
    end else if (alg_we_i) begin
      hash_q    <= start_value(alg_wdata_i);
      rs_mult_q <= RS_START;
      odd_q     <= 1'b0;
    end else if (term) begin
      hash_q    <= start_value(cfg_i.algorithm);
      rs_mult_q <= RS_START;
      odd_q     <= 1'b0;
    end else if (accept) begin
      hash_q    <= hash_d;
      rs_mult_q <= rs_next;
      odd_q     <= ~odd_q;
    end
  end

endmodule

[src/she_queue.sv]
// small queue of finished hashes between front end and back end
// depends on she_pkg
module she_queue import she_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  hash_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output hash_t pop_data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hash_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

[src/she_back.sv]
// back end: bit-serial modulo of the hash by the bucket count, output register
// depends on she_pkg; fed from she_queue
module she_back import she_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BUCKET_W-1:0] bucket_count_i,
  input  logic                q_empty_i,
  input  hash_t               q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hash_t               hash_value_o,
  output logic [BUCKET_W-1:0] bucket_index_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  hash_t               dvd_q;
  hash_t               hash_keep_q;
  logic [BUCKET_W-1:0] rem_q;
  logic [BUCKET_W-1:0] div_q;
  hash_t               hash_out_q;
  logic [BUCKET_W-1:0] bucket_out_q;

  logic [BUCKET_W:0]   trial;
  logic [BUCKET_W:0]   trial_sub;
  logic                out_free;
  logic                deliver;
  logic                start;

  assign trial     = {rem_q, dvd_q[HASH_W-1]};
  assign trial_sub = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign start     = (state_q == ST_IDLE) & ~q_empty_i;
  assign deliver   = (state_q == ST_DIV) & (cnt_q == '0) & out_free;
  assign q_pop_o   = start;

  assign out_valid_o    = out_valid_q;
  assign hash_value_o   = hash_out_q;
  assign bucket_index_o = bucket_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_DIV;
            cnt_q   <= CNT_W'(HASH_W);
          end
        end
        ST_DIV: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end else if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dvd_q       <= q_data_i;
      hash_keep_q <= q_data_i;
      rem_q       <= '0;
      div_q       <= bucket_count_i;
    end else if (state_q == ST_DIV && cnt_q != '0) begin
      dvd_q <= dvd_q << 1;
      rem_q <= trial_sub[BUCKET_W-1:0];
    end
    if (deliver) begin
      hash_out_q   <= hash_keep_q;
      bucket_out_q <= (div_q == '0) ? '0 : rem_q;
    end
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_q != '0) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0 && out_valid_q && out_stall_i)
      |=> (state_q == ST_DIV && cnt_q == '0))
    else $error("finished division lost while output blocked");

endmodule

[src/string_hash_engine_unit.sv]
// top level of the string hash engine: config registers, front end, queue, back end
// depends on she_pkg, she_front, she_queue, she_back
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o   | byte_in_i (8b)
//  out     | output    | out_valid_o / out_stall_i | hash_value_o (31b), bucket_index_o (16b)
//  cfg     | input     | cfg_we_i                  | cfg_index_i (2b), cfg_data_i (16b)
//
// bytes are taken one per cycle while the queue has room; each updates the hash register
// a zero byte ends the string: its hash goes into a two-entry queue, state reloads
// the back end takes each string through a load, 31-step restoring remainder and hand-off,
//   one at a time, so short strings back up into the queue and then stall the input
// reset is asynchronous, active low; it loads the register reset values and clears
//   the queue and the output valid flag; no clearing pass is needed
// the input stalls only while the queue is full; the output register holds a result
//   under stall while the next remainder is already being worked out
module string_hash_engine_unit import she_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // byte stream
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            byte_in_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [HASH_W-1:0]     hash_value_o,
  output logic [BUCKET_W-1:0]   bucket_index_o
);

  // configuration registers
  alg_e                algorithm_q;
  logic                signed_bytes_q;
  logic [BUCKET_W-1:0] bucket_count_q;

  logic       alg_we;
  alg_e       alg_wdata;
  front_cfg_t front_cfg;

  // queue hookup
  logic  q_push;
  hash_t q_push_data;
  logic  q_full;
  logic  q_pop;
  hash_t q_pop_data;
  logic  q_empty;

  // an algorithm write also restarts the string in the front end
  assign alg_we    = cfg_we_i & (cfg_index_i == CFG_ALGORITHM);
  assign alg_wdata = alg_e'(cfg_data_i[2:0]);

  assign front_cfg.algorithm    = algorithm_q;
  assign front_cfg.signed_bytes = signed_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algorithm_q    <= ALG_RESET;
      signed_bytes_q <= SIGNED_RESET;
      bucket_count_q <= BUCKET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALGORITHM:    algorithm_q    <= alg_wdata;
        CFG_SIGNED_BYTES: signed_bytes_q <= cfg_data_i[0];
        CFG_BUCKET_COUNT: bucket_count_q <= cfg_data_i[BUCKET_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // hashing front end, one byte per cycle while the queue is not full
  she_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (front_cfg),
    .alg_we_i    (alg_we),
    .alg_wdata_i (alg_wdata),
    .in_valid_i  (in_valid_i),
    .byte_in_i   (byte_in_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_push_data)
  );

  // finished hashes waiting for the remainder unit
  she_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // bucket index and output register
  she_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .q_empty_i      (q_empty),
    .q_data_i       (q_pop_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o),
    .bucket_index_o (bucket_index_o)
  );

endmodule
